FILE: src/bkl_pkg.sv
`default_nettype none

package bkl_pkg;

    localparam int OPCODE_W       = 1;
    localparam int THREAD_ID_W    = 3;
    localparam int STATUS_W       = 2;
    localparam int HOLDER_ID_W    = 3;
    localparam int TICKET_VALUE_W = 8;
    localparam int ACTIVE_W       = 4;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [OPCODE_W-1:0] OP_LOCK   = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_UNLOCK = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_THREAD = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SAT        = 2'd2;

    // Word index of the register, taken from paddr[2].
    localparam logic REG_ACTIVE_THREADS = 1'b0;

    localparam logic [ACTIVE_W-1:0] ACTIVE_THREADS_RST = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAX_SCAN,
        S_WRITE,
        S_MIN_SCAN,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic clear;
        logic sample;
        logic mode_max;
    } scan_ctl_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic                      holder_valid;
        logic [HOLDER_ID_W-1:0]    holder_id;
        logic                      granted;
        logic [TICKET_VALUE_W-1:0] ticket_value;
    } result_t;

endpackage

`default_nettype wire

FILE: src/bkl_if.sv
`default_nettype none

interface bkl_req_if import bkl_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OPCODE_W-1:0]    opcode;
    logic [THREAD_ID_W-1:0] thread_id;

    modport source (output valid, output opcode, output thread_id, input ready);
    modport sink   (input valid, input opcode, input thread_id, output ready);
endinterface

interface bkl_rsp_if import bkl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic                      holder_valid;
    logic [HOLDER_ID_W-1:0]    holder_id;
    logic                      granted;
    logic [TICKET_VALUE_W-1:0] ticket_value;

    modport source (output valid, output status, output holder_valid, output holder_id,
                    output granted, output ticket_value, input ready);
    modport sink   (input valid, input status, input holder_valid, input holder_id,
                    input granted, input ticket_value, output ready);
endinterface

`default_nettype wire

FILE: src/bkl_ticket_mem.sv
`default_nettype none

module bkl_ticket_mem #(
    parameter int DEPTH  = 8,
    parameter int DATA_W = 8,
    parameter int ADDR_W = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              hit_reg;

    // Entries never written since reset read as zero tickets.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
        hit_reg   <= vld_reg[raddr];
    end

    assign rdata = hit_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

FILE: src/bkl_scan_unit.sv
`default_nettype none

module bkl_scan_unit import bkl_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int IDX_W  = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scan_ctl_t         ctl,
    input  wire logic [DATA_W-1:0] data,
    input  wire logic [IDX_W-1:0]  idx,
    output logic      [DATA_W-1:0] best,
    output logic      [IDX_W-1:0]  best_idx,
    output logic                   found
);

    logic [DATA_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [DATA_W-1:0] cmp_a, cmp_b;
    logic              a_gt_b;
    logic              take;

    // One comparator serves both passes; the operands swap for the minimum.
    always_comb
    begin
        cmp_a  = ctl.mode_max ? data : best_reg;
        cmp_b  = ctl.mode_max ? best_reg : data;
        a_gt_b = cmp_a > cmp_b;
        if (ctl.mode_max)
        begin
            take = a_gt_b;
        end
        else
        begin
            take = (data != '0) && (!found_reg || a_gt_b);
        end
    end

    always_comb
    begin
        best_next  = best_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        if (ctl.clear)
        begin
            best_next  = '0;
            idx_next   = '0;
            found_next = 1'b0;
        end
        else if (ctl.sample && take)
        begin
            best_next  = data;
            idx_next   = idx;
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg  <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            best_reg  <= best_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    assign best     = best_reg;
    assign best_idx = idx_reg;
    assign found    = found_reg;

endmodule

`default_nettype wire

FILE: src/bkl_ctrl.sv
`default_nettype none

module bkl_ctrl import bkl_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int IDX_W  = 3,
    parameter int CNT_W  = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    input  wire logic [OPCODE_W-1:0]    req_opcode,
    input  wire logic [THREAD_ID_W-1:0] req_thread_id,
    output logic                        req_ready,
    input  wire logic [CNT_W-1:0]       slots,
    input  wire logic                   res_take,
    output logic                        res_valid,
    output result_t                     res,
    output logic                        mem_we,
    output logic      [IDX_W-1:0]       mem_waddr,
    output logic      [DATA_W-1:0]      mem_wdata,
    output logic      [IDX_W-1:0]       mem_raddr,
    output scan_ctl_t                   scan_ctl,
    output logic      [IDX_W-1:0]       scan_tag,
    input  wire logic [DATA_W-1:0]      scan_best,
    input  wire logic [IDX_W-1:0]       scan_idx,
    input  wire logic                   scan_found
);

    ctrl_state_t state_reg, state_next;

    logic [CNT_W-1:0]       iss_cnt_reg, iss_cnt_next;
    logic                   pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]       pipe_idx_reg, pipe_idx_next;
    logic [OPCODE_W-1:0]    op_reg, op_next;
    logic [THREAD_ID_W-1:0] tid_reg, tid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [DATA_W-1:0]      tval_reg, tval_next;

    logic              tid_ok;
    logic              scanning;
    logic              issue;
    logic              accept;
    logic              sat;
    logic [DATA_W-1:0] wr_ticket;

    assign tid_ok   = 32'(req_thread_id) < 32'(slots);
    assign scanning = (state_reg == S_MAX_SCAN) || (state_reg == S_MIN_SCAN);
    assign issue    = scanning && (iss_cnt_reg < slots);
    assign accept   = (state_reg == S_IDLE) && req_valid;

    // The new ticket sticks at the top value once the largest ticket reaches it.
    assign sat       = (scan_best == '1);
    assign wr_ticket = (op_reg == OP_UNLOCK) ? '0 :
                       (sat ? '1 : scan_best + DATA_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (!tid_ok)
                    begin
                        state_next = S_MIN_SCAN;
                    end
                    else if (req_opcode == OP_UNLOCK)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_MAX_SCAN;
                    end
                end
            end
            S_MAX_SCAN:
            begin
                if (!issue)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_MIN_SCAN;
            end
            S_MIN_SCAN:
            begin
                if (!issue)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready         = 1'b0;
        res_valid         = 1'b0;
        mem_we            = 1'b0;
        scan_ctl.clear    = 1'b0;
        scan_ctl.mode_max = 1'b0;
        scan_ctl.sample   = pipe_vld_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready      = 1'b1;
                scan_ctl.clear = 1'b1;
            end
            S_MAX_SCAN:
            begin
                scan_ctl.mode_max = 1'b1;
            end
            S_WRITE:
            begin
                mem_we         = 1'b1;
                scan_ctl.clear = 1'b1;
            end
            S_MIN_SCAN:
            begin
                scan_ctl.mode_max = 1'b0;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        op_next       = op_reg;
        tid_next      = tid_reg;
        status_next   = status_reg;
        tval_next     = tval_reg;
        iss_cnt_next  = issue ? iss_cnt_reg + CNT_W'(1) : '0;
        pipe_vld_next = issue;
        pipe_idx_next = iss_cnt_reg[IDX_W-1:0];
        if (accept)
        begin
            op_next     = req_opcode;
            tid_next    = req_thread_id;
            status_next = tid_ok ? STAT_OK : STAT_BAD_THREAD;
            tval_next   = '0;
        end
        else if ((state_reg == S_WRITE) && (op_reg == OP_LOCK))
        begin
            tval_next   = wr_ticket;
            status_next = sat ? STAT_SAT : STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            iss_cnt_reg  <= '0;
            pipe_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            iss_cnt_reg  <= iss_cnt_next;
            pipe_vld_reg <= pipe_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= pipe_idx_next;
        op_reg       <= op_next;
        tid_reg      <= tid_next;
        status_reg   <= status_next;
        tval_reg     <= tval_next;
    end

    assign mem_waddr = IDX_W'(tid_reg);
    assign mem_wdata = wr_ticket;
    assign mem_raddr = iss_cnt_reg[IDX_W-1:0];
    assign scan_tag  = pipe_idx_reg;

    always_comb
    begin
        res.status       = status_reg;
        res.holder_valid = scan_found;
        res.holder_id    = scan_found ? HOLDER_ID_W'(scan_idx) : '0;
        res.granted      = (status_reg != STAT_BAD_THREAD) && (op_reg == OP_LOCK) &&
                           scan_found && (scan_idx == IDX_W'(tid_reg));
        res.ticket_value = TICKET_VALUE_W'(tval_reg);
    end

endmodule

`default_nettype wire

FILE: src/bakery_ticket_lock_arbiter.sv
`default_nettype none

// Bakery ticket lock. Each request item on req carries an opcode (lock or
// unlock) and a thread number; each produces exactly one result item on rsp
// with a status, the current holder (smallest nonzero ticket, lowest thread
// on a tie), a grant flag and the requester's ticket.
// The APB port holds one register, active_threads, at byte address 0.
// Write it only while no item is in flight.
// An item is worked through by one shared comparator: a lock request scans
// all n slots in use for the largest ticket, writes the new ticket, then
// scans again for the smallest nonzero ticket. An unlock writes a zero
// ticket and then scans for the smallest; a rejected thread number only
// scans for the smallest. The scan length is set by the single read port
// of the ticket memory, one slot per cycle.
// req.ready is high only between items. A finished result sits in the output
// register; while rsp is stalled the next item may be accepted and worked,
// and its result waits until the register frees.
// Reset empties every ticket and sets active_threads to 8.
module bakery_ticket_lock_arbiter import bkl_pkg::*; #(
    parameter int MAX_THREADS = 8,
    parameter int TICKET_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bkl_req_if.sink                    req,
    bkl_rsp_if.source                  rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int IDX_W = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);

    logic [ACTIVE_W-1:0] active_threads_reg, active_threads_next;
    logic [CNT_W-1:0]    slots;
    logic                cfg_wr;

    logic    out_vld_reg, out_vld_next;
    result_t out_res_reg;
    result_t res;
    logic    res_valid;
    logic    res_take;
    logic    res_load;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [TICKET_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]       mem_raddr;
    logic [TICKET_BITS-1:0] mem_rdata;

    scan_ctl_t              scan_ctl;
    logic [IDX_W-1:0]       scan_tag;
    logic [TICKET_BITS-1:0] scan_best;
    logic [IDX_W-1:0]       scan_idx;
    logic                   scan_found;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_THREADS);

    always_comb
    begin
        active_threads_next = active_threads_reg;
        if (cfg_wr)
        begin
            active_threads_next = pwdata[ACTIVE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ACTIVE_THREADS)
        begin
            prdata = APB_DATA_W'(active_threads_reg);
        end
    end

    // Slots in use: the register value, capped at the table depth.
    always_comb
    begin
        if (32'(active_threads_reg) > 32'(MAX_THREADS))
        begin
            slots = CNT_W'(MAX_THREADS);
        end
        else
        begin
            slots = CNT_W'(active_threads_reg);
        end
    end

    assign res_take = !out_vld_reg || rsp.ready;
    assign res_load = res_valid && res_take;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (res_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_threads_reg <= ACTIVE_THREADS_RST;
            out_vld_reg        <= 1'b0;
        end
        else
        begin
            active_threads_reg <= active_threads_next;
            out_vld_reg        <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= res;
        end
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.status       = out_res_reg.status;
    assign rsp.holder_valid = out_res_reg.holder_valid;
    assign rsp.holder_id    = out_res_reg.holder_id;
    assign rsp.granted      = out_res_reg.granted;
    assign rsp.ticket_value = out_res_reg.ticket_value;

    bkl_ctrl #(
        .DATA_W (TICKET_BITS),
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_opcode    (req.opcode),
        .req_thread_id (req.thread_id),
        .req_ready     (req.ready),
        .slots         (slots),
        .res_take      (res_take),
        .res_valid     (res_valid),
        .res           (res),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .scan_ctl      (scan_ctl),
        .scan_tag      (scan_tag),
        .scan_best     (scan_best),
        .scan_idx      (scan_idx),
        .scan_found    (scan_found)
    );

    bkl_ticket_mem #(
        .DEPTH  (MAX_THREADS),
        .DATA_W (TICKET_BITS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bkl_scan_unit #(
        .DATA_W (TICKET_BITS),
        .IDX_W  (IDX_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .data     (mem_rdata),
        .idx      (scan_tag),
        .best     (scan_best),
        .best_idx (scan_idx),
        .found    (scan_found)
    );

endmodule

`default_nettype wire

FILE: src/bkl_checker.sv
`default_nettype none

module bkl_checker import bkl_pkg::*; (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      req_valid,
    input wire logic                      req_ready,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_ready,
    input wire logic [STATUS_W-1:0]       rsp_status,
    input wire logic                      rsp_holder_valid,
    input wire logic [HOLDER_ID_W-1:0]    rsp_holder_id,
    input wire logic                      rsp_granted,
    input wire logic [TICKET_VALUE_W-1:0] rsp_ticket_value
);

    logic [1:0] pending_reg, pending_next;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // Items accepted whose result has not yet been delivered.
    always_comb
    begin
        pending_next = pending_reg;
        if (req_acc && !rsp_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (rsp_acc && !req_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("request accepted in back-to-back cycles");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pending_reg != 2'd0))
        else $error("result offered with no item outstanding");

    a_grant_has_holder: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_granted) |-> (rsp_holder_valid && (rsp_status != STAT_BAD_THREAD)))
        else $error("grant without a valid holder");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid &&
            $stable({rsp_status, rsp_holder_valid, rsp_holder_id, rsp_granted,
                     rsp_ticket_value})))
        else $error("stalled result changed");

endmodule

bind bakery_ticket_lock_arbiter bkl_checker u_bkl_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_holder_valid (rsp.holder_valid),
    .rsp_holder_id    (rsp.holder_id),
    .rsp_granted      (rsp.granted),
    .rsp_ticket_value (rsp.ticket_value)
);

`default_nettype wire

FILE: verif/bakery_ticket_lock_arbiter_test.sv
`timescale 1ns / 100ps

module bakery_ticket_lock_arbiter_test;
    import bkl_pkg::*;

    localparam int SLOT_COUNT = 8;
    localparam logic [TICKET_VALUE_W-1:0] TICKET_TOP = {TICKET_VALUE_W{1'b1}};
    // Long enough to finish a lock with every slot in use, with margin.
    localparam int DRAIN_CYCLES = 2 * SLOT_COUNT + 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [APB_ADDR_W-1:0] ACTIVE_THREADS_ADDR = {REG_ACTIVE_THREADS, 2'b00};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bkl_req_if req_ch ();
    bkl_rsp_if rsp_ch ();

    bakery_ticket_lock_arbiter u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch.sink),
        .rsp     (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [TICKET_VALUE_W-1:0] ticket_mirror [SLOT_COUNT];
    logic [ACTIVE_W-1:0]       active_mirror;
    result_t                   expected_results [$];
    int                        error_count;
    bit                        idle_on;
    int                        ready_hold;
    int                        quiet_cycles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int slots_in_use();
        return (active_mirror > SLOT_COUNT) ? SLOT_COUNT : int'(active_mirror);
    endfunction

    // Applies one item to the ticket mirror and returns the result it must produce.
    function automatic result_t predict_lock_result(input logic [OPCODE_W-1:0] op,
                                                    input logic [THREAD_ID_W-1:0] tid);
        result_t                   r;
        int                        slots;
        logic [TICKET_VALUE_W-1:0] top;
        bit                        found;
        slots = slots_in_use();
        r = '0;
        if (int'(tid) >= slots)
        begin
            r.status = STAT_BAD_THREAD;
        end
        else if (op == OP_LOCK)
        begin
            top = '0;
            for (int k = 0; k < slots; k++)
                if (ticket_mirror[k] > top)
                    top = ticket_mirror[k];
            if (top == TICKET_TOP)
            begin
                r.ticket_value = TICKET_TOP;
                r.status = STAT_SAT;
            end
            else
            begin
                r.ticket_value = top + 1'b1;
                r.status = STAT_OK;
            end
            ticket_mirror[tid] = r.ticket_value;
        end
        else
        begin
            ticket_mirror[tid] = '0;
            r.status = STAT_OK;
        end
        found = 1'b0;
        for (int k = 0; k < slots; k++)
        begin
            if (ticket_mirror[k] != 0 && (!found || ticket_mirror[k] < ticket_mirror[r.holder_id]))
            begin
                found = 1'b1;
                r.holder_id = HOLDER_ID_W'(k);
            end
        end
        r.holder_valid = found;
        r.granted = (r.status != STAT_BAD_THREAD) && (op == OP_LOCK) && found
                    && (r.holder_id == tid);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    // valid stays high so that a following item can go out without a gap.
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [THREAD_ID_W-1:0] tid);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.thread_id <= tid;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_results.push_back(predict_lock_result(op, tid));
        @(negedge clk);
    endtask

    task automatic settle_block();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_active_threads(input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ACTIVE_THREADS_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        active_mirror = value[ACTIVE_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Result side: stalls come in bursts while idling is on.
    always @(negedge clk)
    begin
        if (ready_hold != 0)
        begin
            ready_hold--;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            rsp_ch.ready <= 1'b0;
            ready_hold = $urandom_range(1, 19) - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            ready_hold = $urandom_range(0, 30);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result item arrived with none expected");
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              rsp_ch.status, want.status));
                if (rsp_ch.holder_valid !== want.holder_valid)
                    report_mismatch($sformatf("holder_valid got %0d expected %0d",
                                              rsp_ch.holder_valid, want.holder_valid));
                if (rsp_ch.holder_id !== want.holder_id)
                    report_mismatch($sformatf("holder_id got %0d expected %0d",
                                              rsp_ch.holder_id, want.holder_id));
                if (rsp_ch.granted !== want.granted)
                    report_mismatch($sformatf("granted got %0d expected %0d",
                                              rsp_ch.granted, want.granted));
                if (rsp_ch.ticket_value !== want.ticket_value)
                    report_mismatch($sformatf("ticket_value got %0d expected %0d",
                                              rsp_ch.ticket_value, want.ticket_value));
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("ERROR: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic test_lock_handoff();
        send_item(OP_UNLOCK, 3);
        send_item(OP_LOCK, 0);
        send_item(OP_LOCK, 7);
        // Relock by thread 0 moves it behind thread 7.
        send_item(OP_LOCK, 0);
        send_item(OP_UNLOCK, 7);
        send_item(OP_UNLOCK, 0);
        send_item(OP_LOCK, 5);
        send_item(OP_LOCK, 2);
        send_item(OP_UNLOCK, 5);
        send_item(OP_UNLOCK, 2);
    endtask

    task automatic test_thread_range();
        settle_block();
        write_active_threads(3);
        send_item(OP_LOCK, 2);
        send_item(OP_LOCK, 3);
        send_item(OP_LOCK, 7);
        send_item(OP_UNLOCK, 6);
        send_item(OP_UNLOCK, 2);
        // With no slot in use every thread is turned away.
        settle_block();
        write_active_threads(0);
        send_item(OP_LOCK, 0);
        send_item(OP_UNLOCK, 0);
        // Values above the slot count are capped at eight.
        settle_block();
        write_active_threads(15);
        send_item(OP_LOCK, 7);
        send_item(OP_UNLOCK, 7);
    endtask

    task automatic test_inactive_slots();
        settle_block();
        write_active_threads(32'h5A5A_5A58);
        send_item(OP_LOCK, 6);
        send_item(OP_LOCK, 7);
        // Slots 6 and 7 keep their tickets but drop out of every scan.
        settle_block();
        write_active_threads(1);
        send_item(OP_LOCK, 0);
        send_item(OP_LOCK, 6);
        settle_block();
        write_active_threads(8);
        send_item(OP_LOCK, 1);
        send_item(OP_UNLOCK, 0);
        send_item(OP_UNLOCK, 6);
        send_item(OP_UNLOCK, 7);
        send_item(OP_UNLOCK, 1);
    endtask

    task automatic test_ticket_saturation();
        settle_block();
        write_active_threads(2);
        send_item(OP_LOCK, 0);
        // Each relock raises the largest ticket by one until it pins at the top.
        repeat (TICKET_TOP + 4) send_item(OP_LOCK, 1);
        send_item(OP_LOCK, 0);
        send_item(OP_UNLOCK, 0);
        send_item(OP_UNLOCK, 1);
    endtask

    task automatic run_random_phase(input logic [APB_DATA_W-1:0] setting, input int count);
        int                     slots;
        int                     pick;
        int                     holder;
        logic [OPCODE_W-1:0]    op;
        logic [THREAD_ID_W-1:0] tid;
        settle_block();
        write_active_threads(setting);
        repeat (count)
        begin
            slots = slots_in_use();
            pick = $urandom_range(0, 9);
            holder = -1;
            for (int k = 0; k < slots; k++)
                if (ticket_mirror[k] != 0
                    && (holder < 0 || ticket_mirror[k] < ticket_mirror[holder]))
                    holder = k;
            if (slots == 0 || pick >= 8)
            begin
                op = $urandom_range(0, 1) ? OP_UNLOCK : OP_LOCK;
                tid = THREAD_ID_W'($urandom_range(0, SLOT_COUNT - 1));
            end
            else if (pick < 4)
            begin
                op = OP_LOCK;
                tid = THREAD_ID_W'($urandom_range(0, slots - 1));
            end
            else
            begin
                // Mostly the holder releases, so the lock passes along the queue.
                op = OP_UNLOCK;
                if (pick < 7 && holder >= 0)
                    tid = THREAD_ID_W'(holder);
                else
                    tid = THREAD_ID_W'($urandom_range(0, slots - 1));
            end
            send_item(op, tid);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(8, 30);
        run_random_phase(1, 25);
        run_random_phase(5, 30);
        run_random_phase(12, 30);
        run_random_phase(2, 25);
        run_random_phase(0, 10);
        run_random_phase(6, 30);
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        ready_hold = 0;
        run_random_phase(8, 60);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        idle_on          = 1'b1;
        error_count      = 0;
        ready_hold       = 0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = ACTIVE_THREADS_ADDR;
        pwdata           = '0;
        req_ch.valid     = 1'b0;
        req_ch.opcode    = OP_LOCK;
        req_ch.thread_id = '0;
        rsp_ch.ready     = 1'b0;
        for (int k = 0; k < SLOT_COUNT; k++)
            ticket_mirror[k] = '0;
        active_mirror = ACTIVE_THREADS_RST;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_lock_handoff();
        test_thread_range();
        test_inactive_slots();
        test_ticket_saturation();
        test_random_traffic();
        test_full_rate();
        settle_block();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
